[sv/cela_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cela_pkg
// Shared widths, limits and the queue item type of the loss accumulator.
// ----------------------------------------------------------------------------
package cela_pkg;

   localparam int MAX_BATCH  = 256;
   localparam int PROB_W     = 17;
   localparam int EXP_W      = 5;
   localparam int MANT_W     = 31;
   localparam int FRAC_W     = 16;
   localparam int LOSS_W     = 24;
   localparam int ACC_W      = 32;
   localparam int BATCH_W    = 40;
   localparam int EPOCH_CNT_W = 20;
   localparam int SAMP_W     = $clog2(MAX_BATCH + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};

   typedef struct packed {
      logic [PROB_W-1:0] true_prob;
      logic [MANT_W-1:0] mant;       // Q1.30, top bit set
      logic [EXP_W-1:0]  expo;       // index of leading one
      logic              sample_end;
      logic              batch_end;
   } cela_item_type;

endpackage

[sv/cela_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cela_front
// Accepts class elements, clamps and normalises the prediction, and queues.
// ----------------------------------------------------------------------------
module cela_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [cela_pkg::PROB_W-1:0] req_true_prob,
   input  logic [cela_pkg::PROB_W-1:0] req_pred_prob,
   input  logic                        req_sample_end,
   input  logic                        req_batch_end,
   output logic                        q_valid,
   output cela_pkg::cela_item_type     q_item,
   input  logic                        q_pop
);
   import cela_pkg::*;

   cela_item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]          count_ff, count_in;
   logic [PROB_W-1:0]        p_clamp;
   logic [EXP_W-1:0]         expo;
   logic                     push;
   cela_item_type            item;

   always_comb begin
      p_clamp = (req_pred_prob == '0) ? PROB_W'(1) : req_pred_prob;
      expo = '0;
      for (int i = 0; i < PROB_W; i++) begin
         if (p_clamp[i]) expo = EXP_W'(i);
      end
      item.true_prob  = req_true_prob;
      item.mant       = {{(MANT_W-PROB_W){1'b0}}, p_clamp} << (EXP_W'(MANT_W - 1) - expo);
      item.expo       = expo;
      item.sample_end = req_sample_end;
      item.batch_end  = req_sample_end & req_batch_end;
   end

   assign req_stall = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid & ~req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= item;
   end

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overrun");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !q_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

[sv/cela_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cela_back
// Sequencer: iterative log2, term product, accumulators, mean divider and
// the result register.
// ----------------------------------------------------------------------------
module cela_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  cela_pkg::cela_item_type          q_item,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cela_pkg::LOSS_W-1:0]      rsp_loss_value,
   output logic                             rsp_result_kind,
   output logic [cela_pkg::BATCH_W-1:0]     rsp_epoch_total,
   output logic [cela_pkg::EPOCH_CNT_W-1:0] rsp_epoch_batches,
   output logic                             rsp_last
);
   import cela_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_LOG = 4'd1, S_TERM = 4'd2, S_ACC = 4'd3,
                          S_LOSS = 4'd4, S_DLOAD = 4'd5, S_DIV = 4'd6, S_DONE = 4'd7,
                          S_OUT0 = 4'd8, S_OUT1 = 4'd9;
   localparam int DCNT_W = $clog2(BATCH_W);
   localparam int LMAG_W = FRAC_W + EXP_W;
   localparam int PROD_W = PROB_W + LMAG_W;
   localparam int TERM_W = PROD_W - FRAC_W;

   logic [3:0]               state_ff, state_in;
   cela_item_type            item_ff, item_in;
   logic [MANT_W-1:0]        mant_ff, mant_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;
   logic [DCNT_W-1:0]        cnt_ff, cnt_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic signed [ACC_W-1:0]  sacc_ff, sacc_in;
   logic [BATCH_W-1:0]       bacc_ff, bacc_in;
   logic [SAMP_W-1:0]        bsamp_ff, bsamp_in;
   logic [BATCH_W-1:0]       eacc_ff, eacc_in;
   logic [EPOCH_CNT_W-1:0]   ecnt_ff, ecnt_in;
   logic [LOSS_W-1:0]        loss_ff, loss_in, mean_ff, mean_in;
   logic [BATCH_W-1:0]       quo_ff, quo_in;
   logic [SAMP_W-1:0]        rem_ff, rem_in;
   logic                     rv_ff, rv_in, rkind_ff, rkind_in, rlast_ff, rlast_in;
   logic [LOSS_W-1:0]        rloss_ff, rloss_in;
   logic [BATCH_W-1:0]       rtot_ff, rtot_in;
   logic [EPOCH_CNT_W-1:0]   rcnt_ff, rcnt_in;

   logic [2*MANT_W-1:0]      sq;
   logic [MANT_W:0]          sq_sh;
   logic [LMAG_W-1:0]        lmag;
   logic [TERM_W-1:0]        term;
   logic [ACC_W:0]           acc_ext, sum;
   logic [ACC_W:0]           negacc;
   logic [BATCH_W:0]         bsum, esum;
   logic [SAMP_W:0]          trial;
   logic                     out_free, load;

   assign out_free = ~rv_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      sacc_in  = sacc_ff;
      bacc_in  = bacc_ff;
      bsamp_in = bsamp_ff;
      eacc_in  = eacc_ff;
      ecnt_in  = ecnt_ff;
      loss_in  = loss_ff;
      mean_in  = mean_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      rkind_in = rkind_ff;
      rlast_in = rlast_ff;
      rloss_in = rloss_ff;
      rtot_in  = rtot_ff;
      rcnt_in  = rcnt_ff;

      sq    = mant_ff * mant_ff;
      sq_sh = sq[2*MANT_W-1 -: MANT_W+1];
      lmag  = (item_ff.expo == EXP_W'(FRAC_W)) ? LMAG_W'(frac_ff)
            : ((LMAG_W'(EXP_W'(FRAC_W) - item_ff.expo) << FRAC_W) - LMAG_W'(frac_ff));
      term    = prod_ff[PROD_W-1:FRAC_W];
      acc_ext = {sacc_ff[ACC_W-1], sacc_ff};
      sum     = neg_ff ? acc_ext - (ACC_W+1)'(term) : acc_ext + (ACC_W+1)'(term);
      negacc  = '0 - acc_ext;
      bsum    = {1'b0, bacc_ff} + (BATCH_W+1)'(loss_ff);
      esum    = {1'b0, eacc_ff} + (BATCH_W+1)'(mean_ff);
      trial   = {rem_ff, quo_ff[BATCH_W-1]};

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               mant_in  = q_item.mant;
               frac_in  = '0;
               cnt_in   = '0;
               state_in = S_LOG;
            end
         end
         S_LOG: begin
            // one squaring per cycle yields one fraction bit
            frac_in = {frac_ff[FRAC_W-2:0], sq_sh[MANT_W]};
            mant_in = sq_sh[MANT_W] ? sq_sh[MANT_W:1] : sq_sh[MANT_W-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(FRAC_W - 1)) state_in = S_TERM;
         end
         S_TERM: begin
            prod_in  = PROD_W'(item_ff.true_prob) * PROD_W'(lmag);
            neg_in   = (item_ff.expo != EXP_W'(FRAC_W));
            state_in = S_ACC;
         end
         S_ACC: begin
            if (sum[ACC_W] != sum[ACC_W-1])
               sacc_in = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            else
               sacc_in = sum[ACC_W-1:0];
            state_in = item_ff.sample_end ? S_LOSS : S_IDLE;
         end
         S_LOSS: begin
            if (negacc[ACC_W])
               loss_in = '0;
            else if (negacc > (ACC_W+1)'(LOSS_MAX))
               loss_in = LOSS_MAX;
            else
               loss_in = negacc[LOSS_W-1:0];
            sacc_in = '0;
            if (bsamp_ff < SAMP_W'(MAX_BATCH)) bsamp_in = bsamp_ff + 1'b1;
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            // batch sum takes the loss from its register, then divide if needed
            bacc_in  = bsum[BATCH_W] ? {BATCH_W{1'b1}} : bsum[BATCH_W-1:0];
            quo_in   = bsum[BATCH_W] ? {BATCH_W{1'b1}} : bsum[BATCH_W-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = item_ff.batch_end ? S_DIV : S_OUT0;
         end
         S_DIV: begin
            if (trial >= {1'b0, bsamp_ff}) begin
               rem_in = SAMP_W'(trial - {1'b0, bsamp_ff});
               quo_in = {quo_ff[BATCH_W-2:0], 1'b1};
            end else begin
               rem_in = trial[SAMP_W-1:0];
               quo_in = {quo_ff[BATCH_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(BATCH_W - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            mean_in  = (quo_ff[BATCH_W-1:LOSS_W] != '0) ? LOSS_MAX : quo_ff[LOSS_W-1:0];
            if (ecnt_ff != {EPOCH_CNT_W{1'b1}}) ecnt_in = ecnt_ff + 1'b1;
            bacc_in  = '0;
            bsamp_in = '0;
            state_in = S_OUT0;
         end
         S_OUT0: begin
            if (item_ff.batch_end) begin
               eacc_in = esum[BATCH_W] ? {BATCH_W{1'b1}} : esum[BATCH_W-1:0];
            end
            if (out_free) begin
               load     = 1'b1;
               rloss_in = loss_ff;
               rkind_in = 1'b0;
               rtot_in  = '0;
               rcnt_in  = ecnt_ff;
               rlast_in = ~item_ff.batch_end;
               state_in = item_ff.batch_end ? S_OUT1 : S_IDLE;
            end
         end
         S_OUT1: begin
            if (out_free) begin
               load     = 1'b1;
               rloss_in = mean_ff;
               rkind_in = 1'b1;
               rtot_in  = eacc_ff;
               rcnt_in  = ecnt_ff;
               rlast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // epoch sum is added once only: hold while the first result waits
      if (state_ff == S_OUT0 && item_ff.batch_end && !out_free) eacc_in = eacc_ff;
      if (state_ff == S_OUT0 && item_ff.batch_end && out_free)
         eacc_in = esum[BATCH_W] ? {BATCH_W{1'b1}} : esum[BATCH_W-1:0];

      rv_in = load ? 1'b1 : (rsp_stall ? rv_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         sacc_ff  <= '0;
         bacc_ff  <= '0;
         bsamp_ff <= '0;
         eacc_ff  <= '0;
         ecnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         sacc_ff  <= sacc_in;
         bacc_ff  <= bacc_in;
         bsamp_ff <= bsamp_in;
         eacc_ff  <= eacc_in;
         ecnt_ff  <= ecnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      mant_ff  <= mant_in;
      frac_ff  <= frac_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      loss_ff  <= loss_in;
      mean_ff  <= mean_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      rkind_ff <= rkind_in;
      rlast_ff <= rlast_in;
      rloss_ff <= rloss_in;
      rtot_ff  <= rtot_in;
      rcnt_ff  <= rcnt_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_loss_value    = rloss_ff;
   assign rsp_result_kind   = rkind_ff;
   assign rsp_epoch_total   = rtot_ff;
   assign rsp_epoch_batches = rcnt_ff;
   assign rsp_last          = rlast_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> bsamp_ff != '0) else $error("divide by zero count");
   a_samp_bound: assert property (@(posedge clock) disable iff (reset)
      bsamp_ff <= SAMP_W'(MAX_BATCH)) else $error("sample count past limit");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !(rv_ff && rsp_stall)) else $error("result overwritten");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE) else $error("pop while busy");

endmodule

[sv/cross_entropy_loss_accumulator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_entropy_loss_accumulator_core
// Categorical cross-entropy: sums true * log2(pred) per sample, emits the
// sample loss in Q8.16 and, at batch end, the batch mean with epoch totals.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | true_prob, pred_prob, sample_end, batch_end
//  rsp     | out       | rsp_valid/rsp_stall  | loss_value, result_kind, epoch_total,
//          |           |                      | epoch_batches, last
//
//  An element passes through the back end as dispatch, 16 log2 squarings on
//  the one 31x31 multiplier, term product and accumulate; a sample end adds
//  the loss, batch-sum and result states, a batch end the bit-serial mean divider.
//  A 4-entry queue decouples the req side; req_stall rises when it is full.
//  The result register holds under rsp_stall while work carries on behind it.
//  Reset is synchronous and active high and clears all accumulators.
// ----------------------------------------------------------------------------
module cross_entropy_loss_accumulator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cela_pkg::PROB_W-1:0]      req_true_prob,
   input  logic [cela_pkg::PROB_W-1:0]      req_pred_prob,
   input  logic                             req_sample_end,
   input  logic                             req_batch_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cela_pkg::LOSS_W-1:0]      rsp_loss_value,
   output logic                             rsp_result_kind,
   output logic [cela_pkg::BATCH_W-1:0]     rsp_epoch_total,
   output logic [cela_pkg::EPOCH_CNT_W-1:0] rsp_epoch_batches,
   output logic                             rsp_last
);
   import cela_pkg::*;

   logic          q_valid;
   logic          q_pop;
   cela_item_type q_item;

   // front: clamp zero prediction, find leading one, normalise, queue
   cela_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_true_prob  (req_true_prob),
      .req_pred_prob  (req_pred_prob),
      .req_sample_end (req_sample_end),
      .req_batch_end  (req_batch_end),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // back: log2, accumulation, mean division and result transfer
   cela_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_loss_value    (rsp_loss_value),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_epoch_total   (rsp_epoch_total),
      .rsp_epoch_batches (rsp_epoch_batches),
      .rsp_last          (rsp_last)
   );

endmodule
